// ===== sv/abs_sum_double_accumulator_macros.svh =====
// assertion macros
`ifndef ABS_SUM_DOUBLE_ACCUMULATOR_MACROS_SVH
`define ABS_SUM_DOUBLE_ACCUMULATOR_MACROS_SVH
`define ASD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

// ===== sv/asd_pkg.sv =====
`default_nettype none
package asd_pkg;
	localparam int unsigned QueueDepth = 4;
	localparam logic [63:0] MagMask = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ExpInf = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] QNan = 64'h7FF8_0000_0000_0000;

	typedef struct packed {
		logic [62:0] mag;
		logic present;
		logic last;
	} op_t;

	function automatic logic is_nan(input logic [63:0] b);
		return (b & MagMask) > ExpInf;
	endfunction

	// round-to-nearest-even add of two non-negative doubles
	function automatic logic [63:0] add_pos(input logic [63:0] a_in, input logic [63:0] b_in);
		logic [63:0] a, b;
		logic [11:0] ea, eb, d;
		logic [56:0] ma, mb, sum, mask;
		logic [2:0] low;
		logic [53:0] m;
		logic [63:0] r;
		a = a_in;
		b = b_in;
		if (a < b) begin
			a = b_in;
			b = a_in;
		end
		ea = {1'b0, a[62:52]};
		eb = {1'b0, b[62:52]};
		ma = {4'd0, (ea != 12'd0), a[51:0]};
		mb = {4'd0, (eb != 12'd0), b[51:0]};
		if (ea == 12'd0) ea = 12'd1;
		if (eb == 12'd0) eb = 12'd1;
		ma = ma << 3;
		mb = mb << 3;
		d = ea - eb;
		if (d >= 12'd56) begin
			mb = {56'd0, (mb != 57'd0)};
		end else if (d != 12'd0) begin
			mask = (57'd1 << d[5:0]) - 57'd1;
			mb = (mb >> d[5:0]) | {56'd0, ((mb & mask) != 57'd0)};
		end
		sum = ma + mb;
		if (sum[56]) begin
			sum = (sum >> 1) | {56'd0, sum[0]};
			ea = ea + 12'd1;
		end
		low = sum[2:0];
		m = sum[56:3];
		if (low > 3'd4 || (low == 3'd4 && m[0])) m = m + 54'd1;
		if (m[53]) begin
			m = m >> 1;
			ea = ea + 12'd1;
		end
		if (m[52]) r = {1'b0, ea[10:0], m[51:0]};
		else r = {11'd0, m[52:0]};
		if (ea >= 12'd2047) r = ExpInf;
		if (is_nan(a_in) || is_nan(b_in)) r = QNan;
		else if (a_in == ExpInf || b_in == ExpInf) r = ExpInf;
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/asd_front.sv =====
`default_nettype none
// accepts requests, clears sign, drops items that do nothing, queues the rest
module asd_front #(
	parameter int unsigned Depth = asd_pkg::QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [63:0] value_bits,
	input wire logic element_present,
	input wire logic last,
	output logic q_valid,
	input wire logic q_pop,
	output asd_pkg::op_t q_head
);
	localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
	asd_pkg::op_t mem_q [Depth];
	logic [Aw-1:0] wr_q, rd_q;
	logic [Aw:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == (Aw+1)'(Depth));
	assign push = in_valid && !in_stall && (element_present || last);
	assign q_valid = (cnt_q != '0);
	assign q_head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= '{mag: value_bits[62:0], present: element_present, last: last};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + Aw'(1);
			if (q_pop) rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + Aw'(1);
			cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(q_pop);
		end
	end

`include "abs_sum_double_accumulator_macros.svh"
	`ASD_ASSERT_NEVER(a_no_underflow, q_pop && cnt_q == '0, "pop from empty queue")
	`ASD_ASSERT_NEVER(a_no_overflow, push && cnt_q == (Aw+1)'(Depth), "push into full queue")
	`ASD_ASSERT(a_cnt_step, (push && !q_pop) |=> cnt_q == $past(cnt_q) + (Aw+1)'(1), "count")
endmodule
`default_nettype wire

// ===== sv/asd_back.sv =====
`default_nettype none
// one add per cycle, held by a stalled result; result reg on last
module asd_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_pop,
	input wire asd_pkg::op_t q_head,
	output logic out_valid,
	input wire logic out_stall,
	output logic [63:0] sum_bits
);
	logic [63:0] acc_q, nxt;

	assign q_pop = q_valid && (!q_head.last || !out_valid || !out_stall);
	always_comb begin
		nxt = acc_q;
		if (q_head.present) nxt = asd_pkg::add_pos(acc_q, {1'b0, q_head.mag});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (q_pop) begin
				acc_q <= q_head.last ? 64'd0 : nxt;
				if (q_head.last) out_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.last) sum_bits <= asd_pkg::is_nan(nxt) ? asd_pkg::QNan : nxt;
	end

`include "abs_sum_double_accumulator_macros.svh"
	`ASD_ASSERT(a_hold, (out_valid && out_stall) |=> $stable(sum_bits), "result changed")
	`ASD_ASSERT(a_clear, (q_pop && q_head.last) |=> acc_q == 64'd0, "sum not cleared")
	`ASD_ASSERT_NEVER(a_sign, acc_q[63], "negative sum")
endmodule
`default_nettype wire

// ===== sv/abs_sum_double_accumulator.sv =====
// Result path: a request is queued, added into the running sum; last loads the result register.
// Throughput: one request per cycle while in_stall is low; the loop-carried double add is combinational.
// A four-entry queue parts intake from the adder; results wait in one output register.
// Reset (arst_n low, asynchronous): queue empty, sum +0.0, no result pending.
`default_nettype none
module abs_sum_double_accumulator #(
	parameter int unsigned QueueDepth = asd_pkg::QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [63:0] value_bits,
	input wire logic element_present,
	input wire logic last,
	output logic out_valid,
	input wire logic out_stall,
	output logic [63:0] sum_bits
);
	logic q_valid, q_pop;
	asd_pkg::op_t q_head;

	asd_front #(.Depth(QueueDepth)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .value_bits, .element_present, .last,
		.q_valid, .q_pop, .q_head
	);
	asd_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_head, .out_valid, .out_stall, .sum_bits
	);
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

class dasum_scoreboard;
	logic [63:0] acc;
	logic [63:0] sums_due[$];
	int errors;

	function new();
		acc = '0;
		errors = 0;
	endfunction

	static function logic is_nan64(logic [63:0] b);
		return (b & 64'h7FFF_FFFF_FFFF_FFFF) > 64'h7FF0_0000_0000_0000;
	endfunction

	// same-sign double add, round to nearest even
	static function logic [63:0] add_mag(logic [63:0] x, logic [63:0] y);
		logic [63:0] a, b;
		longint unsigned ea, eb, dd;
		logic [63:0] ma, mb, s, m;
		logic [2:0] g;
		if (is_nan64(x) || is_nan64(y)) return 64'h7FF8_0000_0000_0000;
		if (x == 64'h7FF0_0000_0000_0000 || y == 64'h7FF0_0000_0000_0000)
			return 64'h7FF0_0000_0000_0000;
		a = (x < y) ? y : x;
		b = (x < y) ? x : y;
		ea = a[63:52];
		eb = b[63:52];
		ma = {12'd0, a[51:0]};
		mb = {12'd0, b[51:0]};
		if (ea != 0) ma[52] = 1'b1; else ea = 1;
		if (eb != 0) mb[52] = 1'b1; else eb = 1;
		ma = ma << 3;
		mb = mb << 3;
		dd = ea - eb;
		if (dd >= 56) mb = (mb != 0) ? 64'd1 : 64'd0;
		else if (dd > 0) mb = (mb >> dd) | ((mb & ((64'd1 << dd) - 1)) != 0 ? 64'd1 : 64'd0);
		s = ma + mb;
		if (s[56]) begin
			s = (s >> 1) | {63'd0, s[0]};
			ea++;
		end
		if (ea >= 2047) return 64'h7FF0_0000_0000_0000;
		g = s[2:0];
		m = s >> 3;
		if (g > 3'd4 || (g == 3'd4 && m[0])) m++;
		if (m == (64'd1 << 53)) begin
			m = m >> 1;
			ea++;
			if (ea >= 2047) return 64'h7FF0_0000_0000_0000;
		end
		if (m[52]) return {1'b0, ea[10:0], m[51:0]};
		return m;
	endfunction

	function void note_request(logic [63:0] v, logic pres, logic lst);
		if (pres) acc = add_mag(acc, v & 64'h7FFF_FFFF_FFFF_FFFF);
		if (lst) begin
			sums_due.push_back(is_nan64(acc) ? 64'h7FF8_0000_0000_0000 : acc);
			acc = '0;
		end
	endfunction

	function void check_sum(logic [63:0] got);
		logic [63:0] want;
		if (sums_due.size() == 0) begin
			$display("%0t: unexpected sum_bits %h", $time, got);
			errors++;
			return;
		end
		want = sums_due.pop_front();
		if (got !== want) begin
			$display("%0t: sum_bits expected %h actual %h", $time, want, got);
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [63:0] value_bits = '0;
	logic element_present = 1'b0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [63:0] sum_bits;
	int send_idle = 0;
	int recv_stall = 0;
	longint unsigned cycles = 0;
	dasum_scoreboard sb = new();

	abs_sum_double_accumulator uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.value_bits(value_bits), .element_present(element_present), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .sum_bits(sum_bits)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("TEST FAILED");
			$finish;
		end
		if (out_valid && !out_stall) sb.check_sum(sum_bits);
	end

	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall);

	task automatic send(logic [63:0] v, logic pres, logic lst);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value_bits <= v;
		element_present <= pres;
		last <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(v, pres, lst);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_double();
		logic [63:0] v;
		int k;
		v = {$urandom, $urandom};
		k = $urandom_range(9);
		case (k)
			0: v[62:52] = 11'd0;
			1: v[62:52] = 11'h7FF;
			2: v[62:52] = 11'h7FE;
			3, 4: v[62:52] = 11'(1020 + $urandom_range(6));
			default: ;
		endcase
		if ($urandom_range(19) == 0) v[51:0] = '0;
		return v;
	endfunction

	task automatic random_vectors(int n);
		int len;
		while (n > 0) begin
			len = $urandom_range(8);
			if ($urandom_range(9) == 0) len = $urandom_range(40);
			for (int i = 0; i < len; i++) begin
				send(rand_double(), $urandom_range(7) != 0, 1'b0);
				n--;
			end
			send(rand_double(), 1'($urandom_range(1)), 1'b1);
			n--;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.sums_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: empty, signed zeros, NaN, infinities, subnormals, overflow
		send(64'd0, 1'b0, 1'b1);
		send(64'h8000_0000_0000_0000, 1'b1, 1'b1);
		send(64'h0000_0000_0000_0001, 1'b1, 1'b0);
		send(64'h800F_FFFF_FFFF_FFFF, 1'b1, 1'b0);
		send(64'h1234, 1'b0, 1'b0);
		send(64'h0000_0000_0000_0001, 1'b1, 1'b1);
		send(64'hFFF0_0000_0000_0001, 1'b1, 1'b0);
		send(64'h3FF0_0000_0000_0000, 1'b1, 1'b1);
		send(64'h7FF0_0000_0000_0000, 1'b1, 1'b0);
		send(64'h3FF0_0000_0000_0000, 1'b1, 1'b1);
		send(64'h7FEF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
		send(64'hFFEF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
		send(64'h3FF0_0000_0000_0000, 1'b1, 1'b0);
		send(64'h3CA0_0000_0000_0000, 1'b1, 1'b0);
		send(64'hBCA0_0000_0001_0000, 1'b1, 1'b1);
		send(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
		send(64'h7FF0_0000_0000_0000, 1'b1, 1'b1);
		send(64'h4340_0000_0000_0000, 1'b1, 1'b0);
		send(64'h3FF8_0000_0000_0000, 1'b1, 1'b1);
		random_vectors(130);
		drain();
		repeat (10) @(negedge clk);
		send_idle = 82;
		random_vectors(130);
		send_idle = 0;
		recv_stall = 82;
		random_vectors(130);
		send_idle = 31;
		recv_stall = 31;
		random_vectors(130);
		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.sums_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

`default_nettype wire
